/* sv/rlmc_pkg.sv */
// ----------------------------------------------------------------------------
// rlmc_pkg
// Types, codes and reset values shared by the radio link measure controller.
// ----------------------------------------------------------------------------
package rlmc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MEAS  = 2'd1,
    PH_SEND  = 2'd2,
    PH_RECOV = 2'd3
  } link_phase_t;

  typedef enum logic [1:0] {
    MP_BUSY  = 2'd0,
    MP_IDLE  = 2'd1,
    MP_SLEEP = 2'd2,
    MP_ERROR = 2'd3
  } meas_phase_t;

  localparam logic [1:0] LED_NONE = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_OFF  = 2'd2;

  localparam logic KIND_IRQ  = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  localparam int unsigned BIT_RX_DR  = 6;
  localparam int unsigned BIT_TX_DS  = 5;
  localparam int unsigned BIT_MAX_RT = 4;

  localparam int unsigned CfgAddrW = 4;

  localparam logic [1:0] REG_MEAS_CMD    = 2'd0;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] REG_MEAS_TO     = 2'd2;
  localparam logic [1:0] REG_TX_TO       = 2'd3;

  localparam logic [7:0]  RST_MEAS_CMD    = 8'd1;
  localparam logic [3:0]  RST_MAX_RETRIES = 4'd3;
  localparam logic [15:0] RST_MEAS_TO     = 16'd5000;
  localparam logic [15:0] RST_TX_TO       = 16'd100;

  typedef struct packed {
    logic        kind;
    logic        radio_ready;
    logic [7:0]  radio_status;
    logic        irq_pin_low;
    logic [7:0]  command_byte;
    logic [1:0]  meas_phase;
    logic        sensors_present;
    logic        start_accepted;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic [7:0] clear_irq_mask;
    logic       flush_tx_fifo;
    logic       start_meas;
    logic       reinit_meas;
    logic       send_frame;
    logic       start_receive;
    logic       reset_radio;
    logic [1:0] led_command;
    logic       tx_finished;
    logic       tx_acked;
    logic [3:0] retry_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  meas_cmd;
    logic [3:0]  max_retries;
    logic [15:0] meas_to;
    logic [15:0] tx_to;
  } cfg_t;

endpackage

/* sv/radio_link_measure_controller_unit.sv */
// ----------------------------------------------------------------------------
// radio_link_measure_controller_unit
// Input register, link state machine, result register and configuration registers.
// ----------------------------------------------------------------------------
// Path: an input beat passes the input register, then the result register;
//   the state machine updates as the item leaves the input register.
// Throughput: 1 beat per cycle unless a result waits on out_ready; set by the state update.
// Reset: synchronous, active low; clears state machine, both valid flags
//   and loads the configuration registers with their defaults.
module radio_link_measure_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rlmc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rlmc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlmc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rlmc_pkg::in_item_t  in_data_r;
  logic                in_valid_r;
  rlmc_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  rlmc_pkg::out_item_t result;
  rlmc_pkg::cfg_t      cfg;
  logic                step;

  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rlmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlmc_link_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_acked_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_acked |-> out_data_r.tx_finished)
    else $error("tx_acked without tx_finished");

  a_send_enters_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.send_frame |->
      out_data_r.link_state == rlmc_pkg::PH_SEND)
    else $error("send_frame outside sending state");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tx_finished |->
      out_data_r.link_state == rlmc_pkg::PH_IDLE && out_data_r.start_receive)
    else $error("finished transmit did not return to idle");

  a_empty_takes_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("empty input register stalls");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

/* sv/rlmc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rlmc_cfg_regs
// APB register file holding command code, retry limit and the two timeouts.
// ----------------------------------------------------------------------------
module rlmc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlmc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rlmc_pkg::cfg_t                cfg
);

  rlmc_pkg::cfg_t cfg_r;
  rlmc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        rlmc_pkg::REG_MEAS_CMD:    cfg_nxt.meas_cmd    = pwdata[7:0];
        rlmc_pkg::REG_MAX_RETRIES: cfg_nxt.max_retries = pwdata[3:0];
        rlmc_pkg::REG_MEAS_TO:     cfg_nxt.meas_to     = pwdata[15:0];
        rlmc_pkg::REG_TX_TO:       cfg_nxt.tx_to       = pwdata[15:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rlmc_pkg::REG_MEAS_CMD:    prdata = {24'd0, cfg_r.meas_cmd};
      rlmc_pkg::REG_MAX_RETRIES: prdata = {28'd0, cfg_r.max_retries};
      rlmc_pkg::REG_MEAS_TO:     prdata = {16'd0, cfg_r.meas_to};
      rlmc_pkg::REG_TX_TO:       prdata = {16'd0, cfg_r.tx_to};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.meas_cmd    <= rlmc_pkg::RST_MEAS_CMD;
      cfg_r.max_retries <= rlmc_pkg::RST_MAX_RETRIES;
      cfg_r.meas_to     <= rlmc_pkg::RST_MEAS_TO;
      cfg_r.tx_to       <= rlmc_pkg::RST_TX_TO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/rlmc_link_fsm.sv */
// ----------------------------------------------------------------------------
// rlmc_link_fsm
// Link state machine: interrupt decode, measurement control and timeouts.
// ----------------------------------------------------------------------------
module rlmc_link_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  rlmc_pkg::in_item_t  item,
  input  rlmc_pkg::cfg_t      cfg,
  output rlmc_pkg::out_item_t result
);

  rlmc_pkg::link_phase_t phase_r, phase_nxt;
  logic        irq_pending_r, irq_pending_nxt;
  logic        cmd_pending_r, cmd_pending_nxt;
  logic        tx_busy_r, tx_busy_nxt;
  logic        tx_complete_r, tx_complete_nxt;
  logic        tx_success_r, tx_success_nxt;
  logic        meas_running_r, meas_running_nxt;
  logic [3:0]  retries_r, retries_nxt;
  logic [31:0] tx_start_r, tx_start_nxt;
  logic [31:0] meas_start_r, meas_start_nxt;

  logic        poll;
  logic        handle;
  logic        rx_dr, tx_ds, max_rt;
  logic        cmd_pend_a, tx_complete_a, tx_success_a;
  logic        want_start, took_start, running_a;
  logic [1:0]  eff_phase;
  logic        meas_done, meas_err, retry_ok;
  logic [31:0] meas_age, tx_age;
  logic        meas_late, tx_late;
  logic        in_meas, in_send, in_idle, in_recov;
  logic        go_send, do_reinit, go_meas, tx_end, go_recov;

  assign poll   = (item.kind == rlmc_pkg::KIND_POLL) && item.radio_ready;
  assign handle = poll && irq_pending_r;
  assign rx_dr  = handle && item.radio_status[rlmc_pkg::BIT_RX_DR];
  assign tx_ds  = handle && item.radio_status[rlmc_pkg::BIT_TX_DS];
  assign max_rt = handle && item.radio_status[rlmc_pkg::BIT_MAX_RT];

  assign cmd_pend_a    = cmd_pending_r || (rx_dr && (item.command_byte == cfg.meas_cmd));
  assign tx_complete_a = tx_complete_r || tx_ds || max_rt;
  assign tx_success_a  = max_rt ? 1'b0 : (tx_ds ? 1'b1 : tx_success_r);

  assign in_idle  = poll && (phase_r == rlmc_pkg::PH_IDLE);
  assign in_meas  = poll && (phase_r == rlmc_pkg::PH_MEAS);
  assign in_send  = poll && (phase_r == rlmc_pkg::PH_SEND);
  assign in_recov = poll && (phase_r == rlmc_pkg::PH_RECOV);

  assign want_start = in_meas && !meas_running_r &&
                      ((item.meas_phase == rlmc_pkg::MP_IDLE) ||
                       (item.meas_phase == rlmc_pkg::MP_SLEEP));
  assign took_start = want_start && item.start_accepted;
  assign running_a  = meas_running_r || took_start;
  assign eff_phase  = took_start ? rlmc_pkg::MP_BUSY : item.meas_phase;

  assign meas_age  = item.now_ms - meas_start_r;
  assign tx_age    = item.now_ms - tx_start_r;
  assign meas_late = meas_age > {16'd0, cfg.meas_to};
  assign tx_late   = tx_age > {16'd0, cfg.tx_to};

  assign meas_done = running_a && (eff_phase == rlmc_pkg::MP_SLEEP);
  assign meas_err  = eff_phase == rlmc_pkg::MP_ERROR;
  assign retry_ok  = item.sensors_present && (retries_r < cfg.max_retries);
  assign do_reinit = in_meas && !meas_done && meas_err && retry_ok;
  assign go_send   = in_meas && (meas_done || (meas_err && !retry_ok) ||
                                 (!meas_err && meas_late));
  assign go_meas   = in_idle && cmd_pend_a;
  assign tx_end    = in_send && tx_complete_a;
  assign go_recov  = in_send && !tx_complete_a && tx_busy_r && tx_late;

  always_comb begin
    phase_nxt        = phase_r;
    irq_pending_nxt  = irq_pending_r;
    cmd_pending_nxt  = cmd_pending_r;
    tx_busy_nxt      = tx_busy_r;
    tx_complete_nxt  = tx_complete_r;
    tx_success_nxt   = tx_success_r;
    meas_running_nxt = meas_running_r;
    retries_nxt      = retries_r;
    tx_start_nxt     = tx_start_r;
    meas_start_nxt   = meas_start_r;
    if (item.kind == rlmc_pkg::KIND_IRQ) begin
      irq_pending_nxt = 1'b1;
    end else if (poll) begin
      irq_pending_nxt = 1'b0;
      cmd_pending_nxt = cmd_pend_a;
      tx_complete_nxt = tx_complete_a;
      tx_success_nxt  = tx_success_a;
      case (phase_r)
        rlmc_pkg::PH_IDLE: begin
          irq_pending_nxt = item.irq_pin_low;
          if (go_meas) begin
            cmd_pending_nxt  = 1'b0;
            retries_nxt      = 4'd0;
            meas_running_nxt = 1'b0;
            meas_start_nxt   = item.now_ms;
            phase_nxt        = rlmc_pkg::PH_MEAS;
          end
        end
        rlmc_pkg::PH_MEAS: begin
          meas_running_nxt = running_a;
          if (do_reinit) begin
            retries_nxt      = retries_r + 4'd1;
            meas_running_nxt = 1'b0;
          end
          if (go_send) begin
            tx_complete_nxt = 1'b0;
            tx_success_nxt  = 1'b0;
            tx_busy_nxt     = 1'b1;
            tx_start_nxt    = item.now_ms;
            phase_nxt       = rlmc_pkg::PH_SEND;
          end
        end
        rlmc_pkg::PH_SEND: begin
          if (!tx_complete_a &&
              (item.radio_status[rlmc_pkg::BIT_TX_DS] ||
               item.radio_status[rlmc_pkg::BIT_MAX_RT])) begin
            irq_pending_nxt = 1'b1;
          end
          if (tx_end) begin
            tx_complete_nxt = 1'b0;
            tx_busy_nxt     = 1'b0;
            phase_nxt       = rlmc_pkg::PH_IDLE;
          end else if (go_recov) begin
            phase_nxt = rlmc_pkg::PH_RECOV;
          end
        end
        default: begin
          tx_busy_nxt     = 1'b0;
          tx_complete_nxt = 1'b0;
          tx_success_nxt  = 1'b0;
          cmd_pending_nxt = 1'b0;
          phase_nxt       = rlmc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result                = '0;
    result.link_state     = phase_nxt;
    result.retry_count    = retries_nxt;
    result.clear_irq_mask[rlmc_pkg::BIT_RX_DR]  = rx_dr;
    result.clear_irq_mask[rlmc_pkg::BIT_TX_DS]  = tx_ds;
    result.clear_irq_mask[rlmc_pkg::BIT_MAX_RT] = max_rt;
    result.flush_tx_fifo  = max_rt;
    result.start_meas     = want_start;
    result.reinit_meas    = do_reinit;
    result.send_frame     = go_send;
    result.start_receive  = tx_end || in_recov;
    result.reset_radio    = in_recov;
    result.tx_finished    = tx_end;
    result.tx_acked       = tx_end && tx_success_a;
    if (go_meas) begin
      result.led_command = rlmc_pkg::LED_ON;
    end else if (tx_end || in_recov) begin
      result.led_command = rlmc_pkg::LED_OFF;
    end else begin
      result.led_command = rlmc_pkg::LED_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rlmc_pkg::PH_IDLE;
      irq_pending_r  <= 1'b0;
      cmd_pending_r  <= 1'b0;
      tx_busy_r      <= 1'b0;
      tx_complete_r  <= 1'b0;
      tx_success_r   <= 1'b0;
      meas_running_r <= 1'b0;
      retries_r      <= 4'd0;
      tx_start_r     <= 32'd0;
      meas_start_r   <= 32'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      irq_pending_r  <= irq_pending_nxt;
      cmd_pending_r  <= cmd_pending_nxt;
      tx_busy_r      <= tx_busy_nxt;
      tx_complete_r  <= tx_complete_nxt;
      tx_success_r   <= tx_success_nxt;
      meas_running_r <= meas_running_nxt;
      retries_r      <= retries_nxt;
      tx_start_r     <= tx_start_nxt;
      meas_start_r   <= meas_start_nxt;
    end
  end

endmodule
